// ----- src/kwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and codes for the loser-tree k-way merge.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_REFILL = 2'd3;

    localparam logic [7:0] REG_CHANNEL_COUNT  = 8'd0;
    localparam logic [7:0] REG_ORDER_BY_LOCAL = 8'd1;

    localparam logic [63:0] KEY_ALL_ONES = '1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  channel;
        logic [63:0] xchg_stamp;
        logic [63:0] recv_stamp;
        logic        exhausted;
        logic [15:0] record_type;
    } item_t;

    typedef struct packed {
        logic        end_of_merge;
        logic [3:0]  winner_channel;
        logic [31:0] winner_row;
        logic [63:0] winner_xchg_stamp;
        logic [63:0] winner_recv_stamp;
        logic [15:0] winner_type;
    } result_t;

    typedef struct packed {
        logic        is_end;
        logic [63:0] exch_key;
        logic [63:0] loc_key;
    } head_t;

    function automatic logic [63:0] to_key(input logic [63:0] raw);
        return (raw == KEY_ALL_ONES) ? KEY_ALL_ONES : raw + 64'd1;
    endfunction

endpackage

// ----- src/kway_merge_loser_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_merge_loser_tree
// K-way merge of time-ordered record streams through a loser tree.
// ----------------------------------------------------------------------------
// Channel heads, tree nodes, row counters and type tags sit in synchronous
// RAMs with one write and one read port. Pop waits for the result register
// to be free. Refill writes the head, bumps the row counter (unless the item
// is exhausted) and replays the leaf-to-root path, each level stepping through
// the tree-node RAM read, head RAM read and compare. Build writes every node
// and replays each channel path, fetching the head and then stepping through
// the same per-level reads and compare.
module kway_merge_loser_tree #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_index,
    input  logic [7:0]      cfg_data,
    input  logic            item_valid,
    output logic            item_stall,
    input  kwm_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output kwm_pkg::result_t result
);

    import kwm_pkg::*;

    localparam int SW = $clog2(MAX_CHANNELS + 1);
    localparam int CW = $clog2(MAX_CHANNELS);
    localparam int HW = $bits(head_t);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_INIT  = 10'b0000000010,
        S_BKEY  = 10'b0000000100,
        S_BKEYW = 10'b0000001000,
        S_NODE  = 10'b0000010000,
        S_RDH   = 10'b0000100000,
        S_CMP   = 10'b0001000000,
        S_FROW  = 10'b0010000000,
        S_FROWW = 10'b0100000000,
        S_POUT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]          cnt_cfg_reg, cnt_cfg_next;
    logic                ord_cfg_reg, ord_cfg_next;
    logic [SW-1:0]       bc_reg, bc_next;
    logic                order_reg, order_next;
    logic [SW-1:0]       root_reg, root_next;
    logic [SW-1:0]       lw_reg, lw_next;
    logic                await_reg, await_next;
    logic                building_reg, building_next;
    logic [SW-1:0]       j_reg, j_next;
    logic [SW-1:0]       bs_reg, bs_next;
    logic [SW-1:0]       node_reg, node_next;
    logic [SW-1:0]       cslot_reg, cslot_next;
    head_t               carry_reg, carry_next;
    logic [SW-1:0]       t_reg, t_next;
    logic [MAX_CHANNELS:0] vld_reg, vld_next;
    logic                rd_vld_reg;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic          h_we;
    logic [SW-1:0] h_waddr, h_raddr;
    head_t         h_wdata, h_rdata, rd_head;
    logic          l_we;
    logic [SW-1:0] l_waddr, l_raddr, l_wdata, l_rdata;
    logic          r_we;
    logic [CW-1:0] r_waddr, r_raddr;
    logic [31:0]   r_wdata, r_rdata;
    logic          ty_we;
    logic [15:0]   ty_rdata;

    logic          accept;
    logic [SW-1:0] bc_clamp;
    head_t         new_head;

    kwm_ram #(.WIDTH(HW), .DEPTH(MAX_CHANNELS + 1)) u_head (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    kwm_ram #(.WIDTH(SW), .DEPTH(MAX_CHANNELS + 1)) u_loser (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    kwm_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_row (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    kwm_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_type (
        .clk(clk), .we(ty_we), .waddr(CW'(item.channel)), .wdata(item.record_type),
        .raddr(r_raddr), .rdata(ty_rdata)
    );

    // true when slot a ranks after slot b
    function automatic logic ranks_after(input head_t a, input logic [SW-1:0] sa,
                                         input head_t b, input logic [SW-1:0] sb,
                                         input logic ord);
        logic [63:0] pa, pb, qa, qb;
        pa = ord ? a.loc_key : a.exch_key;
        pb = ord ? b.loc_key : b.exch_key;
        qa = ord ? a.exch_key : a.loc_key;
        qb = ord ? b.exch_key : b.loc_key;
        if (a.is_end != b.is_end)
            return a.is_end;
        if (pa != pb)
            return pa > pb;
        if (qa != qb)
            return qa > qb;
        return sa > sb;
    endfunction

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign rd_head      = rd_vld_reg ? h_rdata : '0;
    assign bc_clamp     = (int'(cnt_cfg_reg) > MAX_CHANNELS) ? SW'(MAX_CHANNELS)
                                                             : SW'(cnt_cfg_reg);

    always_comb
    begin
        new_head.is_end   = item.exhausted;
        new_head.exch_key = item.exhausted ? KEY_ALL_ONES : to_key(item.xchg_stamp);
        new_head.loc_key  = item.exhausted ? KEY_ALL_ONES : to_key(item.recv_stamp);
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_cfg_next      = cnt_cfg_reg;
        ord_cfg_next      = ord_cfg_reg;
        bc_next           = bc_reg;
        order_next        = order_reg;
        root_next         = root_reg;
        lw_next           = lw_reg;
        await_next        = await_reg;
        building_next     = building_reg;
        j_next            = j_reg;
        bs_next           = bs_reg;
        node_next         = node_reg;
        cslot_next        = cslot_reg;
        carry_next        = carry_reg;
        t_next            = t_reg;
        vld_next          = vld_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        h_we    = 1'b0;
        h_waddr = SW'(item.channel);
        h_wdata = new_head;
        h_raddr = root_reg;
        l_we    = 1'b0;
        l_waddr = node_reg;
        l_wdata = cslot_reg;
        l_raddr = node_reg;
        r_we    = 1'b0;
        r_waddr = CW'(item.channel);
        r_wdata = '0;
        r_raddr = CW'(root_reg);
        ty_we   = 1'b0;

        if (cfg_valid)
        begin
            if (cfg_index == REG_CHANNEL_COUNT)
                cnt_cfg_next = cfg_data[4:0];
            else if (cfg_index == REG_ORDER_BY_LOCAL)
                ord_cfg_next = cfg_data[0];
        end

        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.cmd)
                        CMD_LOAD:
                        begin
                            if (int'(item.channel) < MAX_CHANNELS)
                            begin
                                h_we  = 1'b1;
                                r_we  = 1'b1;
                                ty_we = 1'b1;
                                vld_next[SW'(item.channel)] = 1'b1;
                            end
                        end
                        CMD_BUILD:
                        begin
                            bc_next            = bc_clamp;
                            order_next         = ord_cfg_reg;
                            vld_next[bc_clamp] = 1'b0;
                            lw_next            = '0;
                            await_next         = 1'b0;
                            j_next             = '0;
                            root_next          = bc_clamp;
                            building_next      = 1'b1;
                            state_next         = S_INIT;
                        end
                        CMD_POP:
                        begin
                            state_next = S_POUT;
                        end
                        CMD_REFILL:
                        begin
                            if (await_reg)
                            begin
                                await_next = 1'b0;
                                if (lw_reg < bc_reg)
                                begin
                                    h_we            = 1'b1;
                                    h_waddr         = lw_reg;
                                    vld_next[lw_reg] = 1'b1;
                                    carry_next      = new_head;
                                    cslot_next      = lw_reg;
                                    node_next       = SW'(({1'b0, lw_reg} + {1'b0, bc_reg}) >> 1);
                                    building_next   = 1'b0;
                                    state_next      = item.exhausted ? S_NODE : S_FROW;
                                end
                            end
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                l_we    = 1'b1;
                l_waddr = j_reg;
                l_wdata = bc_reg;
                if (j_reg == bc_reg)
                begin
                    if (bc_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        bs_next    = bc_reg - SW'(1);
                        state_next = S_BKEY;
                    end
                end
                else
                begin
                    j_next = j_reg + SW'(1);
                end
            end
            S_BKEY:
            begin
                h_raddr    = bs_reg;
                state_next = S_BKEYW;
            end
            S_BKEYW:
            begin
                carry_next = rd_head;
                cslot_next = bs_reg;
                node_next  = SW'(({1'b0, bs_reg} + {1'b0, bc_reg}) >> 1);
                state_next = S_NODE;
            end
            S_NODE:
            begin
                if (node_reg == '0)
                begin
                    root_next = cslot_reg;
                    if (building_reg && bs_reg != '0)
                    begin
                        bs_next    = bs_reg - SW'(1);
                        state_next = S_BKEY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_RDH;
                end
            end
            S_RDH:
            begin
                t_next     = l_rdata;
                h_raddr    = l_rdata;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (ranks_after(carry_reg, cslot_reg, rd_head, t_reg, order_reg))
                begin
                    l_we       = 1'b1;
                    carry_next = rd_head;
                    cslot_next = t_reg;
                end
                node_next  = node_reg >> 1;
                state_next = S_NODE;
            end
            S_FROW:
            begin
                r_raddr    = CW'(lw_reg);
                state_next = S_FROWW;
            end
            S_FROWW:
            begin
                r_we       = 1'b1;
                r_waddr    = CW'(lw_reg);
                r_wdata    = r_rdata + 32'd1;
                state_next = S_NODE;
            end
            S_POUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    result_next       = '0;
                    if (root_reg >= bc_reg || rd_head.is_end)
                    begin
                        result_next.end_of_merge = 1'b1;
                        await_next               = 1'b0;
                    end
                    else
                    begin
                        result_next.winner_channel    = 4'(root_reg);
                        result_next.winner_row        = r_rdata;
                        result_next.winner_xchg_stamp = rd_head.exch_key;
                        result_next.winner_recv_stamp = rd_head.loc_key;
                        result_next.winner_type       = ty_rdata;
                        lw_next                       = root_reg;
                        await_next                    = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_cfg_reg      <= '0;
            ord_cfg_reg      <= 1'b0;
            bc_reg           <= '0;
            order_reg        <= 1'b0;
            root_reg         <= '0;
            lw_reg           <= '0;
            await_reg        <= 1'b0;
            building_reg     <= 1'b0;
            j_reg            <= '0;
            bs_reg           <= '0;
            node_reg         <= '0;
            vld_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_cfg_reg      <= cnt_cfg_next;
            ord_cfg_reg      <= ord_cfg_next;
            bc_reg           <= bc_next;
            order_reg        <= order_next;
            root_reg         <= root_next;
            lw_reg           <= lw_next;
            await_reg        <= await_next;
            building_reg     <= building_next;
            j_reg            <= j_next;
            bs_reg           <= bs_next;
            node_reg         <= node_next;
            vld_reg          <= vld_next;
            rd_vld_reg       <= vld_reg[h_raddr];
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cslot_reg  <= cslot_next;
        carry_reg  <= carry_next;
        t_reg      <= t_next;
        result_reg <= result_next;
    end

    a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_POUT))
        else $error("result raised outside pop");

    a_await_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> (lw_reg < bc_reg))
        else $error("pending refill on channel outside tree");

    a_root_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (root_reg <= bc_reg))
        else $error("champion slot beyond sentinel");

    a_node_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (node_reg != '0 && node_reg < bc_reg))
        else $error("tree node out of range");

endmodule

// ----- src/kwm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
